FILE: src/assert_macros.svh
// Assertion macros shared by the grid peak search RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at every rising clock edge outside reset.
`define DGPS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// An implication with the same clocking and reset.
`define DGPS_ASSERT_IMPL(label, ante, cons, msg) \
	`DGPS_ASSERT(label, (ante) |-> (cons), msg)

`endif

FILE: src/dgps_pkg.sv
// Shared constants, codes and types of the density grid peak search.
package dgps_pkg;
	localparam int MAX_CELLS = 64;
	localparam int CELL_AW   = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam int ADDR_W    = 2 * CELL_AW;
	localparam int DEPTH     = MAX_CELLS * MAX_CELLS;
	localparam int QW        = CELL_AW + 1;
	localparam int NUM_W     = 36;
	localparam int DEN_W     = 31;

	typedef enum logic [1:0] {
		CMD_CLEAR     = 2'd0,
		CMD_DEPOSIT   = 2'd1,
		CMD_SET_REACH = 2'd2,
		CMD_PEAK      = 2'd3
	} cmd_t;

	localparam logic [2:0] CFG_ORIGIN    = 3'd0;
	localparam logic [2:0] CFG_CELL_SIZE = 3'd1;
	localparam logic [2:0] CFG_CELLS     = 3'd2;
	localparam logic [2:0] CFG_TERRAIN   = 3'd3;
	localparam logic [2:0] CFG_TOL       = 3'd4;

	typedef struct packed {
		logic          done;
		logic          neg;
		logic          ovf;
		logic [QW-1:0] q;
	} div_res_t;
endpackage

FILE: src/density_grid_peak_search.sv
// Top level of the density grid peak search: grid memories, control and scan pipeline.
// Peak query: four box bounds from the shared divider, then every cell of the clipped box
// read in turn from the amount memory and passed through the scan pipeline.
// Deposit: two index divisions and a read-modify-write; set reachable is written as it is
// accepted, without leaving idle; clear sweeps all 4096 entries of the amount memory.
// One transaction is worked on at a time; a new one is taken while a result waits.
// After reset a clearing pass zeroes all 4096 amounts and marks every cell reachable.
`include "assert_macros.svh"

module density_grid_peak_search (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         command,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_z,
	input  logic [31:0]        amount,
	input  logic [30:0]        search_radius,
	input  logic               point_reachable,
	input  logic [5:0]         cell_col,
	input  logic [5:0]         cell_row,
	input  logic               reach_bit,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               peak_found,
	output logic signed [31:0] peak_x,
	output logic signed [31:0] peak_z,
	output logic [31:0]        peak_amount
);
	import dgps_pkg::*;

	localparam int CW     = 40;
	localparam int FULL_W = 2 * DEN_W + 1;
	localparam int D_W    = FULL_W - 16;

	typedef enum logic [8:0] {
		ST_CLR     = 9'b000000001,
		ST_IDLE    = 9'b000000010,
		ST_DIV     = 9'b000000100,
		ST_DEP_RD  = 9'b000001000,
		ST_DEP_WR  = 9'b000010000,
		ST_PREP    = 9'b000100000,
		ST_SCAN    = 9'b001000000,
		ST_DRAIN   = 9'b010000000,
		ST_DONE    = 9'b100000000
	} state_t;

	function automatic logic [ADDR_W-1:0] addr_of(input logic [CELL_AW-1:0] row,
	                                               input logic [CELL_AW-1:0] col);
		return ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_CELLS) + ADDR_W'(col));
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [CW-1:0] v);
		logic signed [31:0] r;
		if (v > $signed(CW'(32'sh7FFFFFFF))) r = 32'sh7FFFFFFF;
		else if (v < $signed(CW'(32'sh80000000))) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

	// Configuration registers.
	logic signed [31:0] origin_q;
	logic [DEN_W-1:0]   csize_q;
	logic [6:0]         ncells_q;
	logic               tc_q;
	logic [15:0]        tol_q;

	// Control state.
	state_t             st_q;
	logic [ADDR_W-1:0]  clr_cnt_q;
	logic               clr_reach_q;
	logic [1:0]         sel_q;
	logic               div_start_q;
	div_res_t           dres_q [4];
	div_res_t           div_res;

	// The transaction being worked on.
	cmd_t               cmd_q;
	logic signed [31:0] px_q;
	logic signed [31:0] pz_q;
	logic [31:0]        amt_q;
	logic [DEN_W-1:0]   rad_q;
	logic               pr_q;

	// Memories and their registered read data.
	logic [31:0]        amt_mem [DEPTH];
	logic               reach_mem [DEPTH];
	logic [31:0]        amt_rd_q;
	logic               reach_rd_q;

	// Scan walker.
	logic [CELL_AW-1:0] col_q, row_q, x0_q, x1_q, z1_q;
	logic signed [CW-1:0] cx_q, cz_q, cx0_q;
	logic [2*DEN_W-1:0] rsq_q;

	// Scan pipeline.
	logic               v_s1, v_s2, v_s3, v_s4;
	logic               ok_s2, ok_s3, ok_s4;
	logic [CELL_AW-1:0] col_s1, row_s1, col_s2, row_s2, col_s3, row_s3, col_s4, row_s4;
	logic signed [CW-1:0] cx_s1, cz_s1, cx_s2, cz_s2, cx_s3, cz_s3, cx_s4, cz_s4;
	logic [31:0]        amt_s2, amt_s3, amt_s4;
	logic [DEN_W-1:0]   ux_s2, uz_s2;
	logic [2*DEN_W-1:0] sx_s3, sz_s3;
	logic [D_W-1:0]     d_s4;

	// Best cell so far.
	logic               found_q;
	logic [31:0]        best_amt_q;
	logic [D_W-1:0]     best_d_q;
	logic [CELL_AW-1:0] best_col_q, best_row_q;
	logic signed [CW-1:0] best_cx_q, best_cz_q;

	// Output register.
	logic               out_valid_q;
	logic               found_out_q;
	logic signed [31:0] peak_x_q, peak_z_q;
	logic [31:0]        peak_amt_q;

	// Combinational signals.
	logic               in_acc;
	logic [DEN_W-1:0]   c_eff;
	logic [QW-1:0]      n_eff, n_m1;
	logic               axis_z;
	logic signed [31:0] num_base;
	logic signed [NUM_W-1:0] num_offs, div_num;
	logic               last_sel;
	logic               x0_out, x1_out, z0_out, z1_out, box_empty;
	logic [CELL_AW-1:0] x0, x1, z0, z1;
	logic               dep_drop;
	logic [ADDR_W-1:0]  dep_addr, scan_addr, rd_addr, set_addr;
	logic [32:0]        dep_sum;
	logic [31:0]        dep_sat;
	logic               amt_we, reach_we, set_we;
	logic [ADDR_W-1:0]  amt_wa, reach_wa;
	logic [31:0]        amt_wd;
	logic               reach_wd;
	logic [CELL_AW+DEN_W-1:0] x0_prod, z0_prod;
	logic signed [CW-1:0] cx_start, cz_start, cstep, chalf;
	logic signed [CW-1:0] dx, dz;
	logic [CW-1:0]      ux, uz;
	logic               ok_s1;
	logic [FULL_W-1:0]  full;
	logic               amt_gt, amt_eq, d_lt, d_eq, idx_lt, take;
	logic [31:0]        amt_diff;
	logic [D_W-1:0]     d_diff;
	logic               can_load;

	assign in_stall = (st_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;

	// A zero cell size counts as one LSB; the cell count is clipped to the store.
	assign c_eff = (csize_q == '0) ? DEN_W'(1) : csize_q;
	assign n_eff = (ncells_q == '0) ? QW'(1) :
	               (int'(ncells_q) > MAX_CELLS) ? QW'(MAX_CELLS) : QW'(ncells_q);
	assign n_m1  = n_eff - QW'(1);

	// Divider operands. A deposit needs the x then z index of its point; a query needs
	// the low and high x bound, then the low and high z bound, of its radius box.
	assign axis_z   = (cmd_q == CMD_DEPOSIT) ? sel_q[0] : sel_q[1];
	assign num_base = axis_z ? pz_q : px_q;
	assign num_offs = (cmd_q == CMD_DEPOSIT) ? '0 :
	                  sel_q[0] ? $signed(NUM_W'(rad_q)) : -$signed(NUM_W'(rad_q));
	assign div_num  = NUM_W'(num_base) + num_offs - NUM_W'(origin_q);
	assign last_sel = (cmd_q == CMD_DEPOSIT) ? (sel_q == 2'd1) : (sel_q == 2'd3);

	dgps_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (div_num),
		.den    (c_eff),
		.res    (div_res)
	);

	// Box bounds clipped to the grid. A low bound past the last cell, or a high bound
	// before the first, leaves nothing to scan.
	assign x0_out = !dres_q[0].neg && (dres_q[0].ovf || dres_q[0].q >= n_eff);
	assign x1_out = dres_q[1].neg;
	assign z0_out = !dres_q[2].neg && (dres_q[2].ovf || dres_q[2].q >= n_eff);
	assign z1_out = dres_q[3].neg;
	assign x0 = dres_q[0].neg ? '0 : dres_q[0].q[CELL_AW-1:0];
	assign z0 = dres_q[2].neg ? '0 : dres_q[2].q[CELL_AW-1:0];
	assign x1 = (dres_q[1].ovf || dres_q[1].q > n_m1) ? n_m1[CELL_AW-1:0] :
	            dres_q[1].q[CELL_AW-1:0];
	assign z1 = (dres_q[3].ovf || dres_q[3].q > n_m1) ? n_m1[CELL_AW-1:0] :
	            dres_q[3].q[CELL_AW-1:0];
	assign box_empty = (rad_q == '0) || x0_out || x1_out || z0_out || z1_out ||
	                   (x0 > x1) || (z0 > z1);

	// Deposit target and drop conditions; the index results sit in the first two slots.
	assign dep_drop = (amt_q == '0) || (tc_q && !pr_q) ||
	                  dres_q[0].neg || dres_q[0].ovf || (dres_q[0].q >= n_eff) ||
	                  dres_q[1].neg || dres_q[1].ovf || (dres_q[1].q >= n_eff);
	assign dep_addr = addr_of(dres_q[1].q[CELL_AW-1:0], dres_q[0].q[CELL_AW-1:0]);
	assign dep_sum  = {1'b0, amt_rd_q} + {1'b0, amt_q};
	assign dep_sat  = dep_sum[32] ? '1 : dep_sum[31:0];

	assign scan_addr = addr_of(row_q, col_q);
	assign rd_addr   = (st_q == ST_DEP_RD) ? dep_addr : scan_addr;
	assign set_addr  = addr_of(CELL_AW'(cell_row), CELL_AW'(cell_col));
	assign set_we    = in_acc && (cmd_t'(command) == CMD_SET_REACH) &&
	                   (int'(cell_col) < MAX_CELLS) && (int'(cell_row) < MAX_CELLS);

	// Write ports. The clearing pass owns both memories while it runs; the amount
	// memory is otherwise written only by a deposit, in its write state.
	assign amt_we   = (st_q == ST_CLR) || (st_q == ST_DEP_WR);
	assign amt_wa   = (st_q == ST_CLR) ? clr_cnt_q : dep_addr;
	assign amt_wd   = (st_q == ST_CLR) ? '0 : dep_sat;
	assign reach_we = ((st_q == ST_CLR) && clr_reach_q) || set_we;
	assign reach_wa = (st_q == ST_CLR) ? clr_cnt_q : set_addr;
	assign reach_wd = (st_q == ST_CLR) ? 1'b1 : reach_bit;

	always_ff @(posedge clk) begin
		if (amt_we) amt_mem[amt_wa] <= amt_wd;
		amt_rd_q <= amt_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (reach_we) reach_mem[reach_wa] <= reach_wd;
		reach_rd_q <= reach_mem[rd_addr];
	end

	// Cell centres at the start of the box: origin plus index times cell size plus
	// half a cell. The walker then steps by one cell size per column or row.
	assign x0_prod  = x0 * c_eff;
	assign z0_prod  = z0 * c_eff;
	assign cstep    = $signed(CW'(c_eff));
	assign chalf    = $signed(CW'(c_eff >> 1));
	assign cx_start = $signed(CW'(origin_q)) + $signed(CW'(x0_prod)) + chalf;
	assign cz_start = $signed(CW'(origin_q)) + $signed(CW'(z0_prod)) + chalf;

	// First pipeline stage: the read data for the cell is back. A cell is skipped when
	// it is empty, masked off, or lies outside the radius on either axis.
	assign dx    = cx_s1 - CW'(px_q);
	assign dz    = cz_s1 - CW'(pz_q);
	assign ux    = dx[CW-1] ? CW'(-dx) : CW'(dx);
	assign uz    = dz[CW-1] ? CW'(-dz) : CW'(dz);
	assign ok_s1 = v_s1 && (amt_rd_q != '0) && (!tc_q || reach_rd_q) &&
	               (ux <= CW'(rad_q)) && (uz <= CW'(rad_q));

	assign full = FULL_W'(sx_s3) + FULL_W'(sz_s3);

	// Cell choice: a clearly larger amount wins; with amounts equal within tolerance a
	// clearly shorter distance wins; with both equal the lower x, then lower z, index.
	assign amt_gt   = 33'(amt_s4) > (33'(best_amt_q) + 33'(tol_q));
	assign amt_diff = (amt_s4 > best_amt_q) ? amt_s4 - best_amt_q : best_amt_q - amt_s4;
	assign amt_eq   = amt_diff <= 32'(tol_q);
	assign d_lt     = (best_d_q >= D_W'(tol_q)) && (d_s4 < best_d_q - D_W'(tol_q));
	assign d_diff   = (d_s4 > best_d_q) ? d_s4 - best_d_q : best_d_q - d_s4;
	assign d_eq     = d_diff <= D_W'(tol_q);
	assign idx_lt   = (col_s4 < best_col_q) || ((col_s4 == best_col_q) && (row_s4 < best_row_q));
	assign take     = v_s4 && ok_s4 &&
	                  (!found_q || amt_gt || (amt_eq && (d_lt || (d_eq && idx_lt))));

	assign can_load = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q <= 32'shFFC00000;
			csize_q  <= 31'd131072;
			ncells_q <= 7'd64;
			tc_q     <= 1'b0;
			tol_q    <= 16'd7;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_ORIGIN:    origin_q <= cfg_data;
				CFG_CELL_SIZE: csize_q  <= cfg_data[DEN_W-1:0];
				CFG_CELLS:     ncells_q <= cfg_data[6:0];
				CFG_TERRAIN:   tc_q     <= cfg_data[0];
				CFG_TOL:       tol_q    <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// Main sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_CLR;
			clr_cnt_q   <= '0;
			clr_reach_q <= 1'b1;
			sel_q       <= '0;
			div_start_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			unique case (st_q)
				ST_CLR: begin
					clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
					if (clr_cnt_q == ADDR_W'(DEPTH - 1)) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						unique case (cmd_t'(command))
							CMD_CLEAR: begin
								st_q        <= ST_CLR;
								clr_cnt_q   <= '0;
								clr_reach_q <= 1'b0;
							end
							CMD_DEPOSIT, CMD_PEAK: begin
								st_q        <= ST_DIV;
								sel_q       <= '0;
								div_start_q <= 1'b1;
							end
							CMD_SET_REACH: st_q <= ST_IDLE;
							default: st_q <= ST_IDLE;
						endcase
					end
				end
				ST_DIV: begin
					if (div_res.done) begin
						if (last_sel) begin
							st_q <= (cmd_q == CMD_DEPOSIT) ? ST_DEP_RD : ST_PREP;
						end else begin
							sel_q       <= sel_q + 2'd1;
							div_start_q <= 1'b1;
						end
					end
				end
				ST_DEP_RD: st_q <= dep_drop ? ST_IDLE : ST_DEP_WR;
				ST_DEP_WR: st_q <= ST_IDLE;
				ST_PREP:   st_q <= box_empty ? ST_DONE : ST_SCAN;
				ST_SCAN: begin
					if ((col_q == x1_q) && (row_q == z1_q)) begin
						st_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!(v_s1 || v_s2 || v_s3 || v_s4)) begin
						st_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (can_load) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Transaction fields and divider results.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q <= cmd_t'(command);
			px_q  <= pos_x;
			pz_q  <= pos_z;
			amt_q <= amount;
			rad_q <= search_radius;
			pr_q  <= point_reachable;
		end
		if ((st_q == ST_DIV) && div_res.done) begin
			dres_q[sel_q] <= div_res;
		end
	end

	// Box walker: rows outer, columns inner, one memory read a cycle.
	always_ff @(posedge clk) begin
		if (st_q == ST_PREP) begin
			col_q <= x0;
			row_q <= z0;
			x0_q  <= x0;
			x1_q  <= x1;
			z1_q  <= z1;
			cx_q  <= cx_start;
			cx0_q <= cx_start;
			cz_q  <= cz_start;
			rsq_q <= rad_q * rad_q;
		end else if (st_q == ST_SCAN) begin
			if (col_q == x1_q) begin
				col_q <= x0_q;
				cx_q  <= cx0_q;
				row_q <= row_q + CELL_AW'(1);
				cz_q  <= cz_q + cstep;
			end else begin
				col_q <= col_q + CELL_AW'(1);
				cx_q  <= cx_q + cstep;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= (st_q == ST_SCAN);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Payload of the scan pipeline: squares after the axis check, then the exact
	// radius compare and the Q31.16 squared distance used for tie breaking.
	always_ff @(posedge clk) begin
		col_s1 <= col_q;
		row_s1 <= row_q;
		cx_s1  <= cx_q;
		cz_s1  <= cz_q;

		ok_s2  <= ok_s1;
		amt_s2 <= amt_rd_q;
		col_s2 <= col_s1;
		row_s2 <= row_s1;
		cx_s2  <= cx_s1;
		cz_s2  <= cz_s1;
		ux_s2  <= ux[DEN_W-1:0];
		uz_s2  <= uz[DEN_W-1:0];

		ok_s3  <= ok_s2;
		amt_s3 <= amt_s2;
		col_s3 <= col_s2;
		row_s3 <= row_s2;
		cx_s3  <= cx_s2;
		cz_s3  <= cz_s2;
		sx_s3  <= ux_s2 * ux_s2;
		sz_s3  <= uz_s2 * uz_s2;

		ok_s4  <= ok_s3 && (full <= FULL_W'(rsq_q));
		amt_s4 <= amt_s3;
		col_s4 <= col_s3;
		row_s4 <= row_s3;
		cx_s4  <= cx_s3;
		cz_s4  <= cz_s3;
		d_s4   <= full[FULL_W-1:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (st_q == ST_PREP) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_amt_q <= amt_s4;
			best_d_q   <= d_s4;
			best_col_q <= col_s4;
			best_row_q <= row_s4;
			best_cx_q  <= cx_s4;
			best_cz_q  <= cz_s4;
		end
	end

	// Output register: loaded when the previous result has gone or is going now.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((st_q == ST_DONE) && can_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((st_q == ST_DONE) && can_load) begin
			found_out_q <= found_q;
			peak_x_q    <= found_q ? sat32(best_cx_q) : '0;
			peak_z_q    <= found_q ? sat32(best_cz_q) : '0;
			peak_amt_q  <= found_q ? best_amt_q : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign peak_found  = found_out_q;
	assign peak_x      = peak_x_q;
	assign peak_z      = peak_z_q;
	assign peak_amount = peak_amt_q;

	`DGPS_ASSERT(a_result_from_done, $rose(out_valid) |-> $past(st_q == ST_DONE), "result without a finished query")
	`DGPS_ASSERT_IMPL(a_pipe_in_scan, v_s4, (st_q == ST_SCAN) || (st_q == ST_DRAIN), "scan pipeline busy outside a scan")
	`DGPS_ASSERT_IMPL(a_found_nonzero, (st_q == ST_DONE) && found_q, best_amt_q != '0, "winning cell is empty")
endmodule

FILE: src/dgps_div.sv
// Restoring divider that turns a grid offset into a cell index.
module dgps_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [dgps_pkg::NUM_W-1:0] num,
	input  logic        [dgps_pkg::DEN_W-1:0] den,
	output dgps_pkg::div_res_t                res
);
	import dgps_pkg::*;

	localparam int DSH_W = DEN_W + QW;
	localparam int REM_W = NUM_W - 1;
	localparam int CMP_W = ((DSH_W > REM_W) ? DSH_W : REM_W) + 1;
	localparam int CNT_W = $clog2(QW + 1);

	logic             busy_q;
	logic             first_q;
	logic             done_q;
	logic             neg_q;
	logic             ovf_q;
	logic [CNT_W-1:0] cnt_q;
	logic [REM_W-1:0] rem_q;
	logic [DSH_W-1:0] dsh_q;
	logic [QW-1:0]    q_q;
	logic             ge;

	assign ge = CMP_W'(rem_q) >= CMP_W'(dsh_q);

	// The first step only tests whether the quotient overflows the index range.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			first_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				neg_q <= num[NUM_W-1];
				ovf_q <= 1'b0;
				q_q   <= '0;
				rem_q <= num[REM_W-1:0];
				dsh_q <= {den, {QW{1'b0}}};
				cnt_q <= CNT_W'(QW);
				if (num[NUM_W-1]) begin
					done_q <= 1'b1;
				end else begin
					busy_q  <= 1'b1;
					first_q <= 1'b1;
				end
			end else if (busy_q) begin
				dsh_q <= dsh_q >> 1;
				if (first_q) begin
					first_q <= 1'b0;
					if (ge) begin
						ovf_q  <= 1'b1;
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end else begin
					q_q   <= {q_q[QW-2:0], ge};
					if (ge) begin
						rem_q <= rem_q - REM_W'(dsh_q);
					end
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	assign res = '{done: done_q, neg: neg_q, ovf: ovf_q, q: q_q};
endmodule

FILE: test/tb_density_grid_peak_search.sv
// Self-checking testbench of the density grid peak search: deposits, masks and peak queries.
`timescale 1ns / 1ps

module tb_density_grid_peak_search;
	import dgps_pkg::*;

	// Scoreboard: a copy of the grid and its registers, plus the queue of predicted peaks.
	class peak_scoreboard;
		logic signed [31:0] origin;
		logic [30:0] csize;
		logic [6:0] ncells;
		logic terrain;
		logic [15:0] tol;
		logic [31:0] amounts [DEPTH];
		logic reach [DEPTH];
		logic [96:0] pending [$];
		int mismatches;
		int peaks_seen;
		int peaks_found;

		function void init();
			origin = 32'hFFC00000;
			csize = 31'd131072;
			ncells = 7'd64;
			terrain = 1'b0;
			tol = 16'd7;
			for (int i = 0; i < DEPTH; i++) begin
				amounts[i] = '0;
				reach[i] = 1'b1;
			end
			pending.delete();
			mismatches = 0;
			peaks_seen = 0;
			peaks_found = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] val);
			case (idx)
				CFG_ORIGIN: origin = val;
				CFG_CELL_SIZE: csize = val[30:0];
				CFG_CELLS: ncells = val[6:0];
				CFG_TERRAIN: terrain = val[0];
				CFG_TOL: tol = val[15:0];
				default: ;
			endcase
		endfunction

		function longint eff_size();
			return (csize == 0) ? 64'sd1 : longint'({33'd0, csize});
		endfunction

		function longint eff_cells();
			if (ncells == 0) return 1;
			if (ncells > MAX_CELLS) return MAX_CELLS;
			return longint'(ncells);
		endfunction

		// Floor division of the offset from the grid corner by the cell width.
		function longint index_of(longint coord);
			longint d, c, q;
			d = coord - longint'(origin);
			c = eff_size();
			q = d / c;
			if (d % c != 0 && d < 0) q--;
			return q;
		endfunction

		function longint center_of(longint idx);
			longint c;
			c = eff_size();
			return longint'(origin) + idx * c + c / 2;
		endfunction

		function logic [31:0] clamp32(longint v);
			if (v > 64'sd2147483647) v = 64'sd2147483647;
			if (v < -64'sd2147483648) v = -64'sd2147483648;
			return v[31:0];
		endfunction

		// Notes an accepted transaction and updates the grid or predicts a peak.
		function void note_input(cmd_t cmd, logic signed [31:0] px, logic signed [31:0] pz,
				logic [31:0] amt, logic [30:0] rad, logic pr, logic [5:0] col,
				logic [5:0] row, logic rb);
			longint n, ix, iz, x0, x1, z0, z1, r, dx, dz, bix, biz;
			longint unsigned sum, rsq, ux, uz, full, d, v, best_a, best_d, t;
			bit found, take;
			int a;
			n = eff_cells();
			case (cmd)
				CMD_CLEAR: begin
					for (int i = 0; i < DEPTH; i++) amounts[i] = '0;
				end
				CMD_DEPOSIT: begin
					if (amt != 0 && !(terrain && !pr)) begin
						ix = index_of(longint'(px));
						iz = index_of(longint'(pz));
						if (ix >= 0 && iz >= 0 && ix < n && iz < n) begin
							a = int'(iz * MAX_CELLS + ix);
							sum = longint'(amounts[a]) + longint'(amt);
							amounts[a] = (sum > 64'hFFFFFFFF) ? 32'hFFFFFFFF : sum[31:0];
						end
					end
				end
				CMD_SET_REACH: reach[row * MAX_CELLS + col] = rb;
				default: begin
					found = 0;
					best_a = 0;
					best_d = '1;
					bix = -1;
					biz = -1;
					t = tol;
					r = longint'({33'd0, rad});
					if (r > 0) begin
						rsq = r * r;
						x0 = index_of(longint'(px) - r);
						x1 = index_of(longint'(px) + r);
						z0 = index_of(longint'(pz) - r);
						z1 = index_of(longint'(pz) + r);
						if (x0 < 0) x0 = 0;
						if (z0 < 0) z0 = 0;
						if (x1 > n - 1) x1 = n - 1;
						if (z1 > n - 1) z1 = n - 1;
						for (iz = z0; iz <= z1; iz++)
							for (ix = x0; ix <= x1; ix++) begin
								a = int'(iz * MAX_CELLS + ix);
								v = amounts[a];
								if (v == 0 || (terrain && !reach[a])) continue;
								dx = center_of(ix) - longint'(px);
								dz = center_of(iz) - longint'(pz);
								ux = (dx < 0) ? -dx : dx;
								uz = (dz < 0) ? -dz : dz;
								if (ux > r || uz > r) continue;
								full = ux * ux + uz * uz;
								if (full > rsq) continue;
								d = full >> 16;
								take = 0;
								if (v > best_a + t) take = 1;
								else if (((v > best_a) ? v - best_a : best_a - v) <= t) begin
									if (best_d >= t && d < best_d - t) take = 1;
									else if (((d > best_d) ? d - best_d : best_d - d) <= t &&
											(!found || ix < bix || (ix == bix && iz < biz)))
										take = 1;
								end
								if (take) begin
									found = 1;
									best_a = v;
									best_d = d;
									bix = ix;
									biz = iz;
								end
							end
					end
					if (found)
						pending.push_back({1'b1, clamp32(center_of(bix)),
							clamp32(center_of(biz)), best_a[31:0]});
					else
						pending.push_back('0);
				end
			endcase
		endfunction

		function void report(string what, logic [31:0] got, logic [31:0] want);
			mismatches++;
			$display("mismatch on %s: got %h, expected %h", what, got, want);
		endfunction

		// Checks one accepted result against the oldest predicted peak.
		function void check_result(logic f, logic [31:0] x, logic [31:0] z, logic [31:0] a);
			logic [96:0] e;
			if (pending.size() == 0) begin
				report("unexpected result", {31'd0, f}, 32'd0);
				return;
			end
			e = pending.pop_front();
			peaks_seen++;
			if (e[96]) peaks_found++;
			if (f !== e[96]) report("peak_found", {31'd0, f}, {31'd0, e[96]});
			if (x !== e[95:64]) report("peak_x", x, e[95:64]);
			if (z !== e[63:32]) report("peak_z", z, e[63:32]);
			if (a !== e[31:0]) report("peak_amount", a, e[31:0]);
		endfunction
	endclass

	logic clk, arst_n;
	logic cfg_write;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;
	logic in_valid, in_stall;
	logic [1:0] command;
	logic signed [31:0] pos_x, pos_z;
	logic [31:0] amount;
	logic [30:0] search_radius;
	logic point_reachable;
	logic [5:0] cell_col, cell_row;
	logic reach_bit;
	logic out_valid, out_stall;
	logic peak_found;
	logic signed [31:0] peak_x, peak_z;
	logic [31:0] peak_amount;

	peak_scoreboard grid_model;
	int idle_pct;        // chance of an input gap or output stall in percent; zero in phase 5
	bit hold_receiver;   // set while the receiver holds off for a long stretch
	int items_sent;

	density_grid_peak_search dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .pos_x(pos_x), .pos_z(pos_z), .amount(amount),
		.search_radius(search_radius), .point_reachable(point_reachable),
		.cell_col(cell_col), .cell_row(cell_row), .reach_bit(reach_bit),
		.out_valid(out_valid), .out_stall(out_stall),
		.peak_found(peak_found), .peak_x(peak_x), .peak_z(peak_z), .peak_amount(peak_amount)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The run may be long: the clearing pass after reset, every clear sweeping 4096 cells,
	// and full-grid queries that walk all 4096 cells. This bound sits far above that.
	initial begin
		#400ms;
		$display("FAILED: results differ");
		$finish;
	end

	// Receiver side: random stalls, or a long hold-off when the driver asks for one.
	initial begin
		out_stall = 1'b1;
		forever begin
			@(posedge clk);
			if (hold_receiver) begin
				out_stall <= 1'b1;
				for (int i = 0; i < 3000; i++) @(posedge clk);
				hold_receiver = 1'b0;
			end
			out_stall <= ($urandom_range(99) < idle_pct);
		end
	end

	// Every result transaction is checked at the edge where it is accepted.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			grid_model.check_result(peak_found, peak_x, peak_z, peak_amount);
	end

	// Offers one transaction, holding it until the block takes it, with a random gap first.
	// Valid stays high after the accepting edge; the next call or drain() settles it.
	task automatic send_item(cmd_t cmd, logic signed [31:0] px, logic signed [31:0] pz,
			logic [31:0] amt, logic [30:0] rad, logic pr, logic [5:0] col, logic [5:0] row,
			logic rb);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		pos_x <= px;
		pos_z <= pz;
		amount <= amt;
		search_radius <= rad;
		point_reachable <= pr;
		cell_col <= col;
		cell_row <= row;
		reach_bit <= rb;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		grid_model.note_input(cmd, px, pz, amt, rad, pr, col, row, rb);
		items_sent++;
	endtask

	// Waits for every predicted peak, then lets a clear or deposit still in flight finish.
	task automatic drain();
		in_valid <= 1'b0;
		while (grid_model.pending.size() != 0) @(posedge clk);
		repeat (4200) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		grid_model.set_reg(idx, val);
		@(posedge clk);
	endtask

	// A point within a quarter cell of the configured grid most of the time, anywhere otherwise.
	function automatic logic [31:0] grid_point();
		longint c, span;
		c = grid_model.eff_size();
		span = c * grid_model.eff_cells();
		if ($urandom_range(9) == 0) return $urandom;
		return grid_model.clamp32(longint'(grid_model.origin) - c / 4 +
			longint'($urandom_range(32'hFFFFFFFF)) % (span + c / 2));
	endfunction

	// Radius from zero up to five cells, with an occasional huge one.
	function automatic logic [30:0] pick_radius();
		longint c;
		logic [31:0] r;
		c = grid_model.eff_size();
		case ($urandom_range(9))
			0: r = 32'd0;
			1: r = {1'b0, 31'($urandom)};
			default: r = grid_model.clamp32(c * $urandom_range(4) + $urandom_range(
				int'((c > 65536) ? 65536 : c)));
		endcase
		return r[30:0];
	endfunction

	task automatic random_item();
		int pick;
		logic [31:0] amt;
		pick = $urandom_range(99);
		case ($urandom_range(3))
			0: amt = $urandom;
			1: amt = 32'hFFFFFFFF - $urandom_range(3);
			2: amt = $urandom_range(20);
			default: amt = $urandom_range(65535);
		endcase
		if (pick < 2)
			send_item(CMD_CLEAR, $urandom, $urandom, $urandom, 31'($urandom), 1'($urandom),
				6'($urandom), 6'($urandom), 1'($urandom));
		else if (pick < 55)
			send_item(CMD_DEPOSIT, grid_point(), grid_point(), amt, 31'($urandom),
				($urandom_range(4) != 0), 6'($urandom), 6'($urandom), 1'($urandom));
		else if (pick < 65)
			send_item(CMD_SET_REACH, $urandom, $urandom, $urandom, 31'($urandom),
				1'($urandom), 6'($urandom), 6'($urandom), ($urandom_range(3) != 0));
		else
			send_item(CMD_PEAK, grid_point(), grid_point(), $urandom, pick_radius(),
				1'($urandom), 6'($urandom), 6'($urandom), 1'($urandom));
	endtask

	initial begin
		grid_model = new();
		grid_model.init();
		idle_pct = 23;
		hold_receiver = 1'b0;
		items_sent = 0;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		command = CMD_CLEAR;
		pos_x = '0;
		pos_z = '0;
		amount = '0;
		search_radius = '0;
		point_reachable = 1'b0;
		cell_col = '0;
		cell_row = '0;
		reach_bit = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part on the reset grid of 64 cells of 2.0 from -64.0.
		send_item(CMD_DEPOSIT, 32'sh0, 32'sh0, 32'hFFFFFFF0, 0, 1, 0, 0, 0);
		send_item(CMD_DEPOSIT, 32'sh0, 32'sh0, 32'h100, 0, 0, 0, 0, 0);       // saturates
		send_item(CMD_DEPOSIT, 32'sh40000, 32'sh0, 32'hFFFFFFF8, 0, 1, 0, 0, 0); // tie
		send_item(CMD_DEPOSIT, 32'sh0, 32'sh0, 32'h0, 0, 1, 0, 0, 0);         // zero weight
		send_item(CMD_DEPOSIT, 32'sh7FFFFFFF, 32'sh0, 32'h5, 0, 1, 0, 0, 0);  // off grid
		send_item(CMD_DEPOSIT, 32'sh80000000, 32'sh80000000, 32'h5, 0, 1, 0, 0, 0);
		send_item(CMD_DEPOSIT, 32'shFFC00000, 32'shFFC00000, 32'h9, 0, 1, 0, 0, 0);
		send_item(CMD_DEPOSIT, 32'sh3FFFFF, 32'sh3FFFFF, 32'h9, 0, 1, 0, 0, 0);
		send_item(CMD_PEAK, 32'sh0, 32'sh0, 0, 31'd0, 0, 0, 0, 0);            // zero radius
		send_item(CMD_PEAK, 32'sh0, 32'sh0, 0, 31'h80000, 0, 0, 0, 0);
		send_item(CMD_PEAK, 32'sh7FFFFFFF, 32'sh80000000, 0, 31'h7FFFFFFF, 0, 0, 0, 0);
		send_item(CMD_SET_REACH, 0, 0, 0, 0, 0, 6'd32, 6'd32, 1'b0);
		send_item(CMD_SET_REACH, 0, 0, 0, 0, 0, 6'd63, 6'd63, 1'b0);
		send_item(CMD_PEAK, 32'sh0, 32'sh0, 0, 31'h80000, 0, 0, 0, 0);
		send_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
		send_item(CMD_PEAK, 32'sh0, 32'sh0, 0, 31'h7FFFFFFF, 0, 0, 0, 0);     // empty grid
		drain();
		write_reg(CFG_TERRAIN, 32'd1);
		send_item(CMD_DEPOSIT, 32'sh0, 32'sh0, 32'h30000, 0, 0, 0, 0, 0);     // unreachable
		send_item(CMD_DEPOSIT, 32'sh0, 32'sh0, 32'h30000, 0, 1, 0, 0, 0);     // masked cell
		send_item(CMD_DEPOSIT, 32'sh20000, 32'sh0, 32'h10000, 0, 1, 0, 0, 0);
		send_item(CMD_PEAK, 32'sh0, 32'sh0, 0, 31'h40000, 0, 0, 0, 0);
		send_item(CMD_SET_REACH, 0, 0, 0, 0, 0, 6'd32, 6'd32, 1'b1);
		send_item(CMD_PEAK, 32'sh0, 32'sh0, 0, 31'h40000, 0, 0, 0, 0);
		drain();

		// Random phases; each setting is written only once the block has gone quiet.
		for (int phase = 0; phase < 14; phase++) begin
			case (phase % 7)
				0: begin
					write_reg(CFG_ORIGIN, 32'hFFC00000);
					write_reg(CFG_CELL_SIZE, 32'd131072);
					write_reg(CFG_CELLS, 32'd64);
				end
				1: begin
					write_reg(CFG_ORIGIN, 32'h80000000);
					write_reg(CFG_CELL_SIZE, 32'h7FFFFFFF);
					write_reg(CFG_CELLS, 32'd1);
				end
				2: begin
					write_reg(CFG_ORIGIN, 32'h7FFF0000);
					write_reg(CFG_CELL_SIZE, 32'd1);
					write_reg(CFG_CELLS, 32'd127);
				end
				3: begin
					write_reg(CFG_ORIGIN, $urandom);
					write_reg(CFG_CELL_SIZE, 32'd0);
					write_reg(CFG_CELLS, 32'd0);
				end
				4: begin
					write_reg(CFG_ORIGIN, 32'h0);
					write_reg(CFG_CELL_SIZE, $urandom_range(32'h3FFFF, 3));
					write_reg(CFG_CELLS, $urandom_range(16, 2));
				end
				5: begin
					write_reg(CFG_ORIGIN, 32'hFFFF8000);
					write_reg(CFG_CELL_SIZE, 32'd1000);
					write_reg(CFG_CELLS, 32'd8);
				end
				default: begin
					write_reg(CFG_ORIGIN, $urandom);
					write_reg(CFG_CELL_SIZE, $urandom);
					write_reg(CFG_CELLS, $urandom_range(64, 1));
				end
			endcase
			write_reg(CFG_TERRAIN, $urandom_range(1));
			case (phase % 4)
				0: write_reg(CFG_TOL, 32'd0);
				1: write_reg(CFG_TOL, 32'hFFFF);
				2: write_reg(CFG_TOL, 32'd7);
				default: write_reg(CFG_TOL, $urandom_range(64));
			endcase
			idle_pct = (phase == 5) ? 0 : 23;
			if (phase == 3) hold_receiver = 1'b1;
			for (int k = 0; k < 108; k++) random_item();
			drain();
		end
		idle_pct = 23;

		$display("covered %0d transactions, %0d peak queries of which %0d found a cell",
			items_sent, grid_model.peaks_seen, grid_model.peaks_found);
		if (grid_model.mismatches == 0 && grid_model.pending.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
